FILE: rtl/prefix_code_bit_decoder_macros.svh
// Assertion helpers for the prefix code decoder RTL, used by the controller.
`ifndef PREFIX_CODE_BIT_DECODER_MACROS_SVH
`define PREFIX_CODE_BIT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PCBD_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PCBD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pcbd_pkg.sv
`timescale 1ns / 1ps

package pcbd_pkg;

   // Field widths of the request and response channels.
   localparam int CMD_W     = 1;
   localparam int INDEX_W   = 6;
   localparam int PATTERN_W = 32;
   localparam int LENGTH_W  = 6;
   localparam int SYMBOL_W  = 8;
   localparam int STATUS_W  = 2;

   // Width that holds any bit position plus one (code length up to 64).
   localparam int CMP_W = 7;
   // Width that holds any stored symbol before narrowing to the output byte.
   localparam int SYM_WIDE_W = 32;

   // Register file.
   localparam int CFG_W        = 7;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 1'b0,
      CMD_DECODE = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NONE     = 2'd0,
      ST_SYMBOL   = 2'd1,
      ST_LOADED   = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_DRAIN,
      CS_RESULT
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic load;
      logic rd_en;
      logic emit;
      logic emit_load;
   } ctl_cmd_type;

endpackage

FILE: rtl/pcbd_req_if.sv
`timescale 1ns / 1ps

interface pcbd_req_if
   import pcbd_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [INDEX_W-1:0]   entry_index;
   logic [PATTERN_W-1:0] code_pattern;
   logic [LENGTH_W-1:0]  code_length;
   logic [SYMBOL_W-1:0]  symbol_value;
   logic                 code_bit;

   modport source (
      output valid, command, entry_index, code_pattern, code_length, symbol_value,
             code_bit,
      input  ready
   );

   modport sink (
      input  valid, command, entry_index, code_pattern, code_length, symbol_value,
             code_bit,
      output ready
   );
endinterface

FILE: rtl/pcbd_rsp_if.sv
`timescale 1ns / 1ps

interface pcbd_rsp_if
   import pcbd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SYMBOL_W-1:0] symbol;
   logic [INDEX_W-1:0]  matched_entry;

   modport source (
      output valid, status, symbol, matched_entry,
      input  ready
   );

   modport sink (
      input  valid, status, symbol, matched_entry,
      output ready
   );
endinterface

FILE: rtl/pcbd_ram.sv
`timescale 1ns / 1ps

module pcbd_ram #(
   parameter int WIDTH = 46,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pcbd_ctrl.sv
`timescale 1ns / 1ps
`include "prefix_code_bit_decoder_macros.svh"

module pcbd_ctrl
   import pcbd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic [CMD_W-1:0]                     req_command,
   output logic                                 req_ready,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   input  logic [CFG_W-1:0]                     cfg_entries,
   output ctl_cmd_type                          cmd,
   output logic [$clog2(TABLE_ENTRIES)-1:0]     rd_idx,
   output logic [$clog2(TABLE_ENTRIES+1)-1:0]   used
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
   localparam int WIDE_W = (USED_W > CFG_W) ? USED_W : CFG_W;

   ctl_state_type     state_ff, state_in;
   logic [USED_W-1:0] cnt_ff, cnt_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic              load_kind_ff, load_kind_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [USED_W-1:0] cnt_next;
   logic [WIDE_W-1:0] cfg_wide;

   // Entries taking part in matching, saturated to the table size.
   assign cfg_wide = WIDE_W'(cfg_entries);
   assign used = (cfg_wide > WIDE_W'(TABLE_ENTRIES)) ? USED_W'(TABLE_ENTRIES)
                                                     : USED_W'(cfg_wide);

   assign cnt_next  = cnt_ff + USED_W'(1);
   assign rd_idx    = cnt_ff[IDX_W-1:0];
   assign rsp_valid = rsp_valid_ff;

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         cnt_ff       <= '0;
         used_ff      <= '0;
         load_kind_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         load_kind_ff <= load_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      used_in      = used_ff;
      load_kind_in = load_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  cmd.load     = 1'b1;
                  load_kind_in = 1'b1;
                  state_in     = CS_RESULT;
               end else begin
                  cmd.start    = 1'b1;
                  load_kind_in = 1'b0;
                  used_in      = used;
                  cnt_in       = '0;
                  state_in     = (used == '0) ? CS_RESULT : CS_SCAN;
               end
            end
         end
         CS_SCAN: begin
            // One table entry is read per cycle, lowest index first.
            cmd.rd_en = 1'b1;
            cnt_in    = cnt_next;
            if (cnt_next == used_ff) begin
               state_in = CS_DRAIN;
            end
         end
         CS_DRAIN: begin
            // The last entry read is evaluated in this cycle.
            state_in = CS_RESULT;
         end
         CS_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit      = 1'b1;
               cmd.emit_load = load_kind_ff;
               rsp_valid_in  = 1'b1;
               state_in      = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   `PCBD_ASSERT_NEXT(a_load_to_result, clock, reset,
      req_valid && req_ready && (req_command == CMD_LOAD), state_ff == CS_RESULT,
      "load request did not go straight to the result state")
   `PCBD_ASSERT_IMPLIES(a_scan_in_range, clock, reset,
      state_ff == CS_SCAN, cnt_ff < used_ff, "scan index ran past the entries in use")
   `PCBD_ASSERT_NEXT(a_drain_to_result, clock, reset,
      state_ff == CS_DRAIN, state_ff == CS_RESULT, "drain was not followed by result")
   `PCBD_ASSERT_NEXT(a_emit_shows, clock, reset,
      cmd.emit, rsp_valid_ff, "emitted response did not become valid")

endmodule

FILE: rtl/pcbd_dpath.sv
`timescale 1ns / 1ps

module pcbd_dpath
   import pcbd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_CODE_LEN  = 32,
   parameter int SYMBOL_BITS   = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ctl_cmd_type                        cmd,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]   rd_idx,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0] used,
   input  logic [INDEX_W-1:0]                 entry_index,
   input  logic [PATTERN_W-1:0]               code_pattern,
   input  logic [LENGTH_W-1:0]                code_length,
   input  logic [SYMBOL_W-1:0]                symbol_value,
   input  logic                               code_bit,
   output logic [STATUS_W-1:0]                status,
   output logic [SYMBOL_W-1:0]                symbol,
   output logic [INDEX_W-1:0]                 matched_entry
);

   localparam int IDX_W    = $clog2(TABLE_ENTRIES);
   localparam int USED_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int POS_W    = $clog2(MAX_CODE_LEN);
   localparam int CMPI_W   = (USED_W > INDEX_W) ? USED_W : INDEX_W;
   localparam int BITSEL_W = $clog2(PATTERN_W);
   localparam int ENTRY_W  = PATTERN_W + LENGTH_W + SYMBOL_BITS;

   logic [TABLE_ENTRIES-1:0] alive_ff, alive_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic                     found_ff, found_in;
   logic [SYMBOL_BITS-1:0]   sym_ff, sym_in;
   logic [IDX_W-1:0]         hit_ff, hit_in;
   logic                     bit_ff;
   logic                     eval_vld_ff;
   logic [IDX_W-1:0]         eval_idx_ff;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [SYMBOL_W-1:0]      symbol_ff, symbol_in;
   logic [INDEX_W-1:0]       matched_ff, matched_in;

   logic [CMPI_W-1:0]      idx_wide;
   logic                   load_ok;
   logic [IDX_W-1:0]       load_addr;
   logic [SYM_WIDE_W-1:0]  sym_load_wide;
   logic [ENTRY_W-1:0]     wr_data;
   logic [ENTRY_W-1:0]     rd_data;
   logic [PATTERN_W-1:0]   rd_pattern;
   logic [LENGTH_W-1:0]    rd_length;
   logic [SYMBOL_BITS-1:0] rd_symbol;
   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       pos_plus;
   logic [CMP_W-1:0]       len_ext;
   logic                   cw_bit;
   logic                   live;
   logic                   len_hit;
   logic [SYM_WIDE_W-1:0]  sym_out_wide;
   logic [CMPI_W-1:0]      hit_wide;

   // Load address check and the packed table entry.
   assign idx_wide      = CMPI_W'(entry_index);
   assign load_ok       = idx_wide < CMPI_W'(TABLE_ENTRIES);
   assign load_addr     = idx_wide[IDX_W-1:0];
   assign sym_load_wide = SYM_WIDE_W'(symbol_value);
   assign wr_data       = {sym_load_wide[SYMBOL_BITS-1:0], code_length, code_pattern};

   pcbd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.load && load_ok),
      .wr_addr (load_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   assign rd_pattern = rd_data[PATTERN_W-1:0];
   assign rd_length  = rd_data[PATTERN_W+LENGTH_W-1:PATTERN_W];
   assign rd_symbol  = rd_data[ENTRY_W-1:PATTERN_W+LENGTH_W];

   // Compare the stored codeword bit at the current position with the stream bit.
   assign pos_ext  = CMP_W'(pos_ff);
   assign pos_plus = pos_ext + CMP_W'(1);
   assign len_ext  = CMP_W'(rd_length);
   assign cw_bit   = (pos_ext < CMP_W'(PATTERN_W)) ? rd_pattern[pos_ext[BITSEL_W-1:0]]
                                                   : 1'b0;
   assign live     = (cw_bit == bit_ff) && ((pos_ff == '0) || alive_ff[eval_idx_ff]);
   assign len_hit  = (len_ext == pos_plus) && (len_ext <= CMP_W'(MAX_CODE_LEN));

   // Alive flag updates.
   always_comb begin
      alive_in = alive_ff;
      if (cmd.start) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (USED_W'(i) >= used) begin
               alive_in[i] = 1'b0;
            end
         end
      end
      if (cmd.load && load_ok) begin
         alive_in[load_addr] = 1'b0;
      end
      if (eval_vld_ff) begin
         alive_in[eval_idx_ff] = live;
      end
   end

   // The first live entry whose length is reached wins.
   always_comb begin
      found_in = found_ff;
      sym_in   = sym_ff;
      hit_in   = hit_ff;
      if (cmd.start) begin
         found_in = 1'b0;
      end else if (eval_vld_ff && live && len_hit && !found_ff) begin
         found_in = 1'b1;
         sym_in   = rd_symbol;
         hit_in   = eval_idx_ff;
      end
   end

   // Response payload and bit position at the end of a request.
   assign sym_out_wide = SYM_WIDE_W'(sym_ff);
   assign hit_wide     = CMPI_W'(hit_ff);

   always_comb begin
      pos_in     = pos_ff;
      status_in  = status_ff;
      symbol_in  = symbol_ff;
      matched_in = matched_ff;
      if (cmd.emit) begin
         symbol_in  = '0;
         matched_in = '0;
         if (cmd.emit_load) begin
            status_in = ST_LOADED;
         end else if (found_ff) begin
            status_in  = ST_SYMBOL;
            symbol_in  = sym_out_wide[SYMBOL_W-1:0];
            matched_in = hit_wide[INDEX_W-1:0];
            pos_in     = '0;
         end else if (pos_plus >= CMP_W'(MAX_CODE_LEN)) begin
            status_in = ST_OVERFLOW;
            pos_in    = '0;
         end else begin
            status_in = ST_NONE;
            pos_in    = POS_W'(pos_plus);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff    <= '0;
         pos_ff      <= '0;
         found_ff    <= 1'b0;
         eval_vld_ff <= 1'b0;
      end else begin
         alive_ff    <= alive_in;
         pos_ff      <= pos_in;
         found_ff    <= found_in;
         eval_vld_ff <= cmd.rd_en;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      hit_ff      <= hit_in;
      eval_idx_ff <= rd_idx;
      status_ff   <= status_in;
      symbol_ff   <= symbol_in;
      matched_ff  <= matched_in;
      if (cmd.start) begin
         bit_ff <= code_bit;
      end
   end

   assign status        = status_ff;
   assign symbol        = symbol_ff;
   assign matched_entry = matched_ff;

endmodule

FILE: rtl/prefix_code_bit_decoder.sv
// Load request: the entry is written on acceptance, then the result state emits the response.
// Decode request, N = entries in use capped at the table size: the table is scanned one entry
// a cycle in the scan state, then drain and result follow (N = 0 goes straight to result).
// Requests are taken only in idle; the result state waits until any earlier response is taken.
// A new request is taken while the previous response still waits in its output register.
// Synchronous active-high reset clears flags, position, entries_in_use and control state.
`timescale 1ns / 1ps

module prefix_code_bit_decoder
   import pcbd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_CODE_LEN  = 32,
   parameter int SYMBOL_BITS   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   pcbd_req_if.sink              req_chan,
   pcbd_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

   logic [CFG_W-1:0]  entries_ff, entries_in;
   logic              csr_write;
   ctl_cmd_type       cmd;
   logic [IDX_W-1:0]  rd_idx;
   logic [USED_W-1:0] used;

   // Register file: entries_in_use at word address zero.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign entries_in = (csr_write && (csr_paddr[2] == REG_ENTRIES_IN_USE))
                       ? csr_pwdata[CFG_W-1:0] : entries_ff;
   assign csr_prdata = (csr_paddr[2] == REG_ENTRIES_IN_USE) ? CSR_DATA_W'(entries_ff)
                                                            : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else begin
         entries_ff <= entries_in;
      end
   end

   pcbd_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .cfg_entries (entries_ff),
      .cmd         (cmd),
      .rd_idx      (rd_idx),
      .used        (used)
   );

   pcbd_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_CODE_LEN  (MAX_CODE_LEN),
      .SYMBOL_BITS   (SYMBOL_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .rd_idx        (rd_idx),
      .used          (used),
      .entry_index   (req_chan.entry_index),
      .code_pattern  (req_chan.code_pattern),
      .code_length   (req_chan.code_length),
      .symbol_value  (req_chan.symbol_value),
      .code_bit      (req_chan.code_bit),
      .status        (rsp_chan.status),
      .symbol        (rsp_chan.symbol),
      .matched_entry (rsp_chan.matched_entry)
   );

endmodule
